>>> sv/pea_pkg.sv
package pea_pkg;

    localparam int CmdW      = 3;
    localparam int PosW      = 32;
    localparam int UnitsW    = 16;
    localparam int RawW      = 16;
    localparam int RestW     = 18;
    localparam int BtnW      = 3;
    localparam int AccW      = 32;
    localparam int InDataW   = 88;
    localparam int OutDataW  = 176;

    // |rest + raw| stays below 2^17, so the quotient magnitude needs 17 bits
    localparam int DivSteps  = 17;
    localparam int DivCntW   = $clog2(DivSteps);

    localparam logic [UnitsW-1:0] UnitsReset = 16'd120;

    localparam logic [CmdW-1:0] CMD_BEGIN   = 3'd0;
    localparam logic [CmdW-1:0] CMD_MOVE    = 3'd1;
    localparam logic [CmdW-1:0] CMD_PRESS   = 3'd2;
    localparam logic [CmdW-1:0] CMD_RELEASE = 3'd3;
    localparam logic [CmdW-1:0] CMD_CANCEL  = 3'd4;
    localparam logic [CmdW-1:0] CMD_WHEEL   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } pea_state_t;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_step;
        logic apply;
        logic load_out;
    } pea_cmd_t;

    typedef struct packed {
        logic wheel_div;
    } pea_sts_t;

    function automatic logic signed [AccW-1:0] sat32(input logic signed [AccW+1:0] v);
        logic signed [AccW-1:0] r;
        if (v[AccW+1:AccW-1] == 3'b000 || v[AccW+1:AccW-1] == 3'b111) begin
            r = v[AccW-1:0];
        end else if (v[AccW+1]) begin
            r = {1'b1, {(AccW-1){1'b0}}};
        end else begin
            r = {1'b0, {(AccW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> sv/pea_ctrl.sv
module pea_ctrl
    import pea_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  pea_sts_t sts,
    output pea_cmd_t cmd
);

    pea_state_t          state_reg, state_next;
    logic [DivCntW-1:0]  cnt_reg, cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                out_free;
    logic                cnt_last;

    assign out_free = !m_tvalid_reg || m_tready;
    assign cnt_last = (cnt_reg == DivCntW'(DivSteps - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC: state_next = sts.wheel_div ? ST_DIV : ST_DONE;
            ST_DIV:  if (cnt_last) state_next = ST_FIN;
            ST_FIN:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_EXEC: begin
                cmd.div_start = sts.wheel_div;
                cmd.apply     = !sts.wheel_div;
            end
            ST_DIV:  cmd.div_step = 1'b1;
            ST_FIN:  cmd.apply    = 1'b1;
            ST_DONE: cmd.load_out = out_free;
            default: cmd = '0;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.div_start) begin
            cnt_next = '0;
        end else if (cmd.div_step) begin
            cnt_next = cnt_reg + DivCntW'(1);
        end
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

>>> sv/pea_dpath.sv
module pea_dpath
    import pea_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CmdW-1:0]     s_tuser,
    input  logic [InDataW-1:0]  s_tdata,
    input  logic                cfg_wr_en,
    input  logic [UnitsW-1:0]   cfg_wr_data,
    input  pea_cmd_t            cmd,
    output pea_sts_t            sts,
    output logic [OutDataW-1:0] m_tdata
);

    // latched item
    logic [CmdW-1:0]          cmd_reg;
    logic signed [PosW-1:0]   px_reg, py_reg;
    logic                     ins_reg;
    logic [BtnW-1:0]          btn_reg;
    logic signed [RawW-1:0]   raw_reg;

    logic [UnitsW-1:0]        units_reg;

    // tracker state
    logic signed [PosW-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic                     inside_reg, inside_next;
    logic                     known_reg, known_next;
    logic [BtnW-1:0]          held_reg, held_next;
    logic [BtnW-1:0]          pressed_reg, pressed_next;
    logic [BtnW-1:0]          released_reg, released_next;
    logic signed [AccW-1:0]   mx_reg, mx_next, my_reg, my_next;
    logic signed [AccW-1:0]   ws_reg, ws_next;
    logic signed [RestW-1:0]  rest_reg, rest_next;
    logic                     acc_next;

    // divider
    logic                     neg_reg;
    logic [DivSteps-1:0]      dvd_reg;
    logic [UnitsW-1:0]        rem_reg;
    logic signed [RestW:0]    wsum;
    logic [RestW:0]           wmag;
    logic [UnitsW:0]          rem_sh;
    logic [UnitsW+1:0]        rem_diff;
    logic signed [RestW-1:0]  q_s, r_s;

    logic [BtnW-1:0]          bbit;
    logic signed [AccW+1:0]   dx_sum, dy_sum, ws_sum;

    logic [OutDataW-1:0]      out_reg;

    assign sts.wheel_div = (cmd_reg == CMD_WHEEL) && (units_reg != '0);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg <= s_tuser;
            px_reg  <= s_tdata[31:0];
            py_reg  <= s_tdata[63:32];
            ins_reg <= s_tdata[64];
            btn_reg <= s_tdata[67:65];
            raw_reg <= s_tdata[83:68];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            units_reg <= UnitsReset;
        end else if (cfg_wr_en) begin
            units_reg <= cfg_wr_data;
        end
    end

    // sign-magnitude restoring division of rest + raw by the step size
    assign wsum     = (RestW+1)'(rest_reg) + (RestW+1)'(raw_reg);
    assign wmag     = wsum[RestW] ? (RestW+1)'(-wsum) : (RestW+1)'(wsum);
    assign rem_sh   = {rem_reg, dvd_reg[DivSteps-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, units_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_reg <= wsum[RestW];
            dvd_reg <= wmag[DivSteps-1:0];
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            if (!rem_diff[UnitsW+1]) begin
                rem_reg <= rem_diff[UnitsW-1:0];
                dvd_reg <= {dvd_reg[DivSteps-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[UnitsW-1:0];
                dvd_reg <= {dvd_reg[DivSteps-2:0], 1'b0};
            end
        end
    end

    assign q_s = neg_reg ? -RestW'(dvd_reg) : RestW'(dvd_reg);
    assign r_s = neg_reg ? -RestW'(rem_reg) : RestW'(rem_reg);

    always_comb begin
        if (btn_reg >= BtnW'(1) && btn_reg <= BtnW'(3)) begin
            bbit = BtnW'(1) << (btn_reg - BtnW'(1));
        end else begin
            bbit = '0;
        end
    end

    assign dx_sum = (AccW+2)'(mx_reg) + (AccW+2)'(px_reg) - (AccW+2)'(sx_reg);
    assign dy_sum = (AccW+2)'(my_reg) + (AccW+2)'(py_reg) - (AccW+2)'(sy_reg);
    assign ws_sum = (AccW+2)'(ws_reg) + (AccW+2)'(q_s);

    always_comb begin
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        inside_next   = inside_reg;
        known_next    = known_reg;
        held_next     = held_reg;
        pressed_next  = pressed_reg;
        released_next = released_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        ws_next       = ws_reg;
        rest_next     = rest_reg;
        acc_next      = 1'b0;
        if (cmd.apply) begin
            unique case (cmd_reg)
                CMD_BEGIN: begin
                    mx_next       = '0;
                    my_next       = '0;
                    ws_next       = '0;
                    pressed_next  = '0;
                    released_next = '0;
                end
                CMD_MOVE: begin
                    if (known_reg) begin
                        mx_next = sat32(dx_sum);
                        my_next = sat32(dy_sum);
                    end
                    sx_next     = px_reg;
                    sy_next     = py_reg;
                    inside_next = ins_reg;
                    known_next  = 1'b1;
                end
                CMD_PRESS: begin
                    if (bbit != '0 && (held_reg & bbit) == '0) begin
                        held_next    = held_reg | bbit;
                        pressed_next = pressed_reg | bbit;
                        acc_next     = 1'b1;
                    end
                end
                CMD_RELEASE: begin
                    if (bbit != '0 && (held_reg & bbit) != '0) begin
                        held_next     = held_reg & ~bbit;
                        released_next = released_reg | bbit;
                        acc_next      = 1'b1;
                    end
                end
                CMD_CANCEL: begin
                    released_next = released_reg | held_reg;
                    held_next     = '0;
                    inside_next   = 1'b0;
                    known_next    = 1'b0;
                end
                CMD_WHEEL: begin
                    if (units_reg != '0) begin
                        ws_next   = sat32(ws_sum);
                        rest_next = r_s;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg       <= '0;
            sy_reg       <= '0;
            inside_reg   <= 1'b0;
            known_reg    <= 1'b0;
            held_reg     <= '0;
            pressed_reg  <= '0;
            released_reg <= '0;
            mx_reg       <= '0;
            my_reg       <= '0;
            ws_reg       <= '0;
            rest_reg     <= '0;
        end else begin
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            inside_reg   <= inside_next;
            known_reg    <= known_next;
            held_reg     <= held_next;
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            mx_reg       <= mx_next;
            my_reg       <= my_next;
            ws_reg       <= ws_next;
            rest_reg     <= rest_next;
        end
    end

    // accepted flag is held from apply until the result is loaded
    logic acc_reg;
    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {4'b0000, known_reg, inside_reg, sy_reg, sx_reg, held_reg,
                        released_reg, pressed_reg, ws_reg, my_reg, mx_reg, acc_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

>>> sv/pointer_event_accumulator_core.sv
// Channel | Ports                              | Contents
// --------+------------------------------------+-----------------------------------------
// input   | s_tvalid s_tready s_tuser s_tdata  | cmd; pos_x pos_y inside_req button raw_wheel
// result  | m_tvalid m_tready m_tdata          | one result per input transfer
// config  | cfg_wr_en cfg_wr_data              | wheel_units_per_step
//
// One item at a time; a wheel command with a nonzero step size also runs the 17 steps
// of the bit-serial remainder divider. The next item is taken while the previous result
// still waits in the output register. aresetn is synchronous and active low; it clears
// all tracker state and sets the step size to 120.
// A stalled result blocks the following item only once that item is finished.
module pointer_event_accumulator_core
    import pea_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CmdW-1:0]     s_tuser,     // cmd
    // pos_x[31:0], pos_y[63:32], inside_req[64], button[67:65], raw_wheel[83:68]
    input  logic [InDataW-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // accepted[0], frame_dx[32:1], frame_dy[64:33], frame_wheel[96:65],
    // pressed_mask[99:97], released_mask[102:100], held_mask[105:103],
    // cur_x[137:106], cur_y[169:138], is_inside[170], valid_position[171]
    output logic [OutDataW-1:0] m_tdata,
    input  logic                cfg_wr_en,
    input  logic [UnitsW-1:0]   cfg_wr_data
);

    pea_cmd_t cmd;
    pea_sts_t sts;

    pea_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pea_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_tdata     (m_tdata)
    );

endmodule

>>> verif/testbench.sv
module testbench
    import pea_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CmdW-1:0] CMD_NOP_A = 3'd6;
    localparam logic [CmdW-1:0] CMD_NOP_B = 3'd7;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam int STALL_CYCLES = 400;
    localparam int IDLE_LIMIT = 3000;
    localparam int PHASE_ITEMS = 340;

    // input payload, first field in the low bits
    typedef struct packed {
        logic [RawW-1:0] raw;
        logic [BtnW-1:0] btn;
        logic            ins;
        logic [PosW-1:0] py;
        logic [PosW-1:0] px;
    } event_fields_t;

    typedef struct {
        logic [CmdW-1:0] cmd;
        event_fields_t   data;
    } pointer_event_t;

    // result payload, first field in the low bits
    typedef struct packed {
        logic            known;
        logic            in_surface;
        logic [PosW-1:0] cur_y;
        logic [PosW-1:0] cur_x;
        logic [BtnW-1:0] held;
        logic [BtnW-1:0] released;
        logic [BtnW-1:0] pressed;
        logic [AccW-1:0] wheel;
        logic [AccW-1:0] dy;
        logic [AccW-1:0] dx;
        logic            accepted;
    } pointer_report_t;

    localparam int InFieldsW = $bits(event_fields_t);
    localparam int ReportW = $bits(pointer_report_t);

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CmdW-1:0]     s_tuser = '0;
    logic [InDataW-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                cfg_wr_en = 1'b0;
    logic [UnitsW-1:0]   cfg_wr_data = '0;

    pointer_event_accumulator_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    pointer_event_t  pending_events[$];
    pointer_report_t expected_reports[$];
    int              mismatches = 0;
    logic            in_xfer = 1'b0;
    logic            calm = 1'b0;
    int              hold_reqs = 0;

    // tracker copy
    logic signed [PosW-1:0]  trk_x, trk_y;
    logic                    trk_inside, trk_known;
    logic [BtnW-1:0]         trk_held, trk_pressed, trk_released;
    logic signed [AccW-1:0]  trk_dx, trk_dy, trk_steps;
    logic signed [RestW-1:0] trk_rest;
    logic [UnitsW-1:0]       trk_units;

    function automatic logic signed [AccW-1:0] clamp_s32(input longint v);
        if (v > S32_MAX) return S32_MAX[AccW-1:0];
        if (v < S32_MIN) return S32_MIN[AccW-1:0];
        return v[AccW-1:0];
    endfunction

    function automatic pointer_report_t track_event(input logic [CmdW-1:0] cmd,
                                                    input event_fields_t d);
        pointer_report_t r;
        logic [BtnW-1:0] sel;
        longint          sum;
        longint          quo;
        sel = (d.btn >= 3'd1 && d.btn <= 3'd3) ? BtnW'(1 << (d.btn - 3'd1)) : '0;
        r = '0;
        case (cmd)
            CMD_BEGIN: begin
                trk_dx = '0;
                trk_dy = '0;
                trk_steps = '0;
                trk_pressed = '0;
                trk_released = '0;
            end
            CMD_MOVE: begin
                if (trk_known) begin
                    trk_dx = clamp_s32(longint'(trk_dx) + longint'($signed(d.px))
                                       - longint'(trk_x));
                    trk_dy = clamp_s32(longint'(trk_dy) + longint'($signed(d.py))
                                       - longint'(trk_y));
                end
                trk_x = d.px;
                trk_y = d.py;
                trk_inside = d.ins;
                trk_known = 1'b1;
            end
            CMD_PRESS: begin
                if (sel != '0 && (trk_held & sel) == '0) begin
                    trk_held = trk_held | sel;
                    trk_pressed = trk_pressed | sel;
                    r.accepted = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (sel != '0 && (trk_held & sel) != '0) begin
                    trk_held = trk_held & ~sel;
                    trk_released = trk_released | sel;
                    r.accepted = 1'b1;
                end
            end
            CMD_CANCEL: begin
                trk_released = trk_released | trk_held;
                trk_held = '0;
                trk_inside = 1'b0;
                trk_known = 1'b0;
            end
            CMD_WHEEL: begin
                if (trk_units != '0) begin
                    sum = longint'(trk_rest) + longint'($signed(d.raw));
                    quo = sum / longint'(trk_units);
                    sum = sum - quo * longint'(trk_units);
                    trk_rest = sum[RestW-1:0];
                    trk_steps = clamp_s32(longint'(trk_steps) + quo);
                end
            end
            default: begin
            end
        endcase
        r.dx = trk_dx;
        r.dy = trk_dy;
        r.wheel = trk_steps;
        r.pressed = trk_pressed;
        r.released = trk_released;
        r.held = trk_held;
        r.cur_x = trk_x;
        r.cur_y = trk_y;
        r.in_surface = trk_inside;
        r.known = trk_known;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // monitor and predictor
    always @(posedge aclk) begin
        pointer_report_t want;
        pointer_report_t got;
        in_xfer <= aresetn && s_tvalid && s_tready;
        if (!aresetn) begin
            trk_x = '0;
            trk_y = '0;
            trk_inside = 1'b0;
            trk_known = 1'b0;
            trk_held = '0;
            trk_pressed = '0;
            trk_released = '0;
            trk_dx = '0;
            trk_dy = '0;
            trk_steps = '0;
            trk_rest = '0;
            trk_units = UnitsReset;
        end else begin
            if (cfg_wr_en) trk_units = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_reports.push_back(track_event(s_tuser, s_tdata[InFieldsW-1:0]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[ReportW-1:0];
                if (expected_reports.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(got.accepted));
                    check_field("frame_dx", want.dx, got.dx);
                    check_field("frame_dy", want.dy, got.dy);
                    check_field("frame_wheel", want.wheel, got.wheel);
                    check_field("pressed_mask", 32'(want.pressed), 32'(got.pressed));
                    check_field("released_mask", 32'(want.released), 32'(got.released));
                    check_field("held_mask", 32'(want.held), 32'(got.held));
                    check_field("cur_x", want.cur_x, got.cur_x);
                    check_field("cur_y", want.cur_y, got.cur_y);
                    check_field("is_inside", 32'(want.in_surface), 32'(got.in_surface));
                    check_field("valid_position", 32'(want.known), 32'(got.known));
                    check_field("padding", 32'd0, 32'(m_tdata[OutDataW-1:ReportW]));
                end
            end
        end
    end

    // event driver
    always @(negedge aclk) begin
        pointer_event_t ev;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_xfer) begin
            if (pending_events.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
                ev = pending_events.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= ev.cmd;
                s_tdata <= {{(InDataW-InFieldsW){1'b0}}, ev.data};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver; a hold request blocks it for a long stretch
    int hold_left = 0;
    int hold_seen = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_seen + 1;
            hold_left <= STALL_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 33);
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus side position, so most moves stay near the last one
    logic [PosW-1:0] gen_x = '0;
    logic [PosW-1:0] gen_y = '0;

    task automatic push_event(input logic [CmdW-1:0] cmd, input logic [PosW-1:0] px,
                              input logic [PosW-1:0] py, input logic ins,
                              input logic [BtnW-1:0] btn, input logic [RawW-1:0] raw);
        pointer_event_t ev;
        ev.cmd = cmd;
        ev.data.px = px;
        ev.data.py = py;
        ev.data.ins = ins;
        ev.data.btn = btn;
        ev.data.raw = raw;
        pending_events.push_back(ev);
    endtask

    task automatic push_random_event();
        pointer_event_t ev;
        int pick;
        pick = $urandom_range(99);
        ev.data.px = $urandom;
        ev.data.py = $urandom;
        ev.data.ins = 1'($urandom_range(1));
        ev.data.btn = BtnW'($urandom_range(7));
        ev.data.raw = RawW'($urandom);
        if (pick < 10) begin
            ev.cmd = CMD_BEGIN;
        end else if (pick < 45) begin
            ev.cmd = CMD_MOVE;
            if ($urandom_range(99) < 85) begin
                ev.data.px = gen_x + PosW'($urandom_range(400)) - 32'd200;
                ev.data.py = gen_y + PosW'($urandom_range(400)) - 32'd200;
            end
            gen_x = ev.data.px;
            gen_y = ev.data.py;
        end else if (pick < 75) begin
            ev.cmd = (pick < 60) ? CMD_PRESS : CMD_RELEASE;
            if ($urandom_range(99) < 85) ev.data.btn = BtnW'($urandom_range(1, 3));
        end else if (pick < 80) begin
            ev.cmd = CMD_CANCEL;
        end else if (pick < 95) begin
            ev.cmd = CMD_WHEEL;
            if ($urandom_range(99) < 80) ev.data.raw = RawW'($urandom_range(720)) - 16'd360;
        end else begin
            ev.cmd = $urandom_range(1) ? CMD_NOP_A : CMD_NOP_B;
        end
        pending_events.push_back(ev);
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || expected_reports.size() != 0 || s_tvalid)
            @(posedge aclk);
        // let a wheel division finish before touching the register
        repeat (30) @(negedge aclk);
    endtask

    task automatic write_units(input logic [UnitsW-1:0] units);
        wait_drained();
        cfg_wr_data <= units;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [UnitsW-1:0] phase_units[5];
        phase_units[0] = 16'd0;
        phase_units[1] = 16'd1;
        phase_units[2] = 16'hFFFF;
        phase_units[3] = UnitsW'($urandom_range(2, 500));
        phase_units[4] = UnitsReset;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // position unknown, then both axes saturate, then a zero move
        push_event(CMD_MOVE, 32'h7FFFFFFF, 32'h80000000, 1'b1, 3'd0, 16'd0);
        push_event(CMD_MOVE, 32'h80000000, 32'h7FFFFFFF, 1'b0, 3'd0, 16'd0);
        push_event(CMD_MOVE, 32'h80000000, 32'h7FFFFFFF, 1'b1, 3'd0, 16'd0);
        // refused buttons, double press and release of a free button
        push_event(CMD_PRESS, 32'd0, 32'd0, 1'b0, 3'd0, 16'd0);
        push_event(CMD_PRESS, 32'd0, 32'd0, 1'b0, 3'd1, 16'd0);
        push_event(CMD_PRESS, 32'd0, 32'd0, 1'b0, 3'd1, 16'd0);
        push_event(CMD_PRESS, 32'd0, 32'd0, 1'b0, 3'd3, 16'd0);
        push_event(CMD_PRESS, 32'd0, 32'd0, 1'b0, 3'd7, 16'd0);
        push_event(CMD_RELEASE, 32'd0, 32'd0, 1'b0, 3'd2, 16'd0);
        push_event(CMD_RELEASE, 32'd0, 32'd0, 1'b0, 3'd3, 16'd0);
        push_event(CMD_RELEASE, 32'd0, 32'd0, 1'b0, 3'd4, 16'd0);
        push_event(CMD_PRESS, 32'd0, 32'd0, 1'b0, 3'd2, 16'd0);
        // cancel releases what is held and forgets the position
        push_event(CMD_CANCEL, 32'd0, 32'd0, 1'b0, 3'd0, 16'd0);
        push_event(CMD_MOVE, 32'd5, 32'hFFFFFFFB, 1'b1, 3'd0, 16'd0);
        push_event(CMD_NOP_A, 32'd0, 32'd0, 1'b0, 3'd0, 16'd0);
        push_event(CMD_NOP_B, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 3'd7, 16'hFFFF);
        // wheel extremes and remainder handling across a frame start
        push_event(CMD_WHEEL, 32'd0, 32'd0, 1'b0, 3'd0, 16'h7FFF);
        push_event(CMD_WHEEL, 32'd0, 32'd0, 1'b0, 3'd0, 16'h8000);
        push_event(CMD_WHEEL, 32'd0, 32'd0, 1'b0, 3'd0, 16'd119);
        push_event(CMD_WHEEL, 32'd0, 32'd0, 1'b0, 3'd0, 16'hFFFF);
        push_event(CMD_BEGIN, 32'd0, 32'd0, 1'b0, 3'd0, 16'd0);
        push_event(CMD_WHEEL, 32'd0, 32'd0, 1'b0, 3'd0, 16'd1);
        push_event(CMD_RELEASE, 32'd0, 32'd0, 1'b0, 3'd1, 16'd0);

        for (int p = 0; p < 5; p++) begin
            write_units(phase_units[p]);
            calm = (p == 2);
            if (p == 1 || p == 3) hold_reqs++;
            for (int i = 0; i < PHASE_ITEMS; i++) push_random_event();
            wait_drained();
            calm = 1'b0;
        end

        repeat (40) @(posedge aclk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
